FILE: hw/rtl/nnscale_pkg.sv
// Package for the nearest-neighbor scaler address unit.
// Holds register indexes, reset values, field widths and the result type.
// No dependencies.
package nnscale_pkg;

  // Fixed field widths.
  localparam int unsigned STEP_W  = 24;
  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned COORD_W = 12;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned INT_W   = ACC_W - FRAC_W;
  localparam int unsigned CIDX_W  = 3;

  // Default largest image dimension.
  localparam int unsigned MAX_DIM_DEF = 4096;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0] STEP_ONE = 24'h01_0000;

  // Configuration register indexes.
  typedef enum logic [CIDX_W-1:0] {
    CFG_STEP_X        = 3'd0,
    CFG_STEP_Y        = 3'd1,
    CFG_TARGET_WIDTH  = 3'd2,
    CFG_TARGET_HEIGHT = 3'd3,
    CFG_SOURCE_WIDTH  = 3'd4,
    CFG_SOURCE_HEIGHT = 3'd5
  } cfg_idx_t;

  // One result transaction.
  typedef struct packed {
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
    logic [COORD_W-1:0] src_col;
    logic [COORD_W-1:0] src_row;
    logic               end_of_row;
    logic               end_of_frame;
  } result_t;

endpackage

FILE: hw/rtl/nearest_neighbor_scale_mirror_addr_unit.sv
// Source-address generator for nearest-neighbor scaling with vertical mirroring.
// Depends on nnscale_pkg for widths, register indexes and the result type.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    in_restart
//   out_     output     out_valid / out_ready  dest_col, dest_row, src_col, src_row,
//                                              end_of_row, end_of_frame
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per clock while in_ready is high: each accepted item is computed
// from counter and accumulators, entering the output or skid register next cycle.
// The per-cycle path is the 40-bit accumulator add and the source clamp compares.
// A two-entry output stage (output register plus skid register) keeps in_ready
// high while one result waits, so a stall costs no throughput until both are full.
// Reset is synchronous and active low; it restores default steps and sizes.
module nearest_neighbor_scale_mirror_addr_unit
  import nnscale_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  // Result channel.
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] out_dest_col,
  output logic [COORD_W-1:0] out_dest_row,
  output logic [COORD_W-1:0] out_src_col,
  output logic [COORD_W-1:0] out_src_row,
  output logic               out_end_of_row,
  output logic               out_end_of_frame,
  // Configuration channel.
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CIDX_W-1:0]  cfg_index,
  input  logic [STEP_W-1:0]  cfg_data
);

  localparam int unsigned CNT_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned SZ_W   = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;
  localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_DIM);

  // Effective configuration: steps with zero taken as one, sizes minus one.
  logic [STEP_W-1:0] step_x_r, step_y_r;
  logic [CNT_W-1:0]  tw_m1_r, th_m1_r, sw_m1_r, sh_m1_r;

  // Frame position state.
  logic [CNT_W-1:0]  col_r, row_r;
  logic [ACC_W-1:0]  xacc_r, yacc_r;

  // Output stage.
  logic              out_valid_r, skid_valid_r;
  result_t           out_r, skid_r;

  logic              in_acc;
  logic [ACC_W-1:0]  half_x, half_y;
  logic [CNT_W-1:0]  col_cur, row_cur;
  logic [ACC_W-1:0]  xacc_cur, yacc_cur;
  logic [INT_W-1:0]  xi, yi;
  logic [INT_W-1:0]  sw_m1_ext, sh_m1_ext;
  logic [INT_W-1:0]  scol_full, srow_full;
  logic              eor, eof;
  result_t           res;
  logic [CNT_W-1:0]  col_nxt, row_nxt;
  logic [ACC_W-1:0]  xacc_nxt, yacc_nxt;
  logic              out_free;

  // Size register value to effective size minus one, clamped to one..MAX_DIM.
  function automatic logic [CNT_W-1:0] size_m1(input logic [SIZE_W-1:0] v);
    logic [SZ_W-1:0] vz;
    logic [SZ_W-1:0] eff;
    vz  = SZ_W'(v);
    eff = (vz == '0) ? SZ_W'(1) : ((vz > MAX_SZ) ? MAX_SZ : vz);
    return CNT_W'(eff - SZ_W'(1));
  endfunction

  // Step register value with zero taken as one.
  function automatic logic [STEP_W-1:0] step_eff(input logic [STEP_W-1:0] v);
    return (v == '0) ? STEP_W'(1) : v;
  endfunction

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_valid_r;
  assign in_acc    = in_valid & in_ready;
  assign out_free  = ~out_valid_r | out_ready;

  // Configuration registers hold effective values ready for the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_x_r <= STEP_ONE;
      step_y_r <= STEP_ONE;
      tw_m1_r  <= '0;
      th_m1_r  <= '0;
      sw_m1_r  <= '0;
      sh_m1_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_X:        step_x_r <= step_eff(cfg_data);
        CFG_STEP_Y:        step_y_r <= step_eff(cfg_data);
        CFG_TARGET_WIDTH:  tw_m1_r  <= size_m1(cfg_data[SIZE_W-1:0]);
        CFG_TARGET_HEIGHT: th_m1_r  <= size_m1(cfg_data[SIZE_W-1:0]);
        CFG_SOURCE_WIDTH:  sw_m1_r  <= size_m1(cfg_data[SIZE_W-1:0]);
        CFG_SOURCE_HEIGHT: sh_m1_r  <= size_m1(cfg_data[SIZE_W-1:0]);
        default: ;
      endcase
    end
  end

  // Starting point of the current pixel, with a restart folded in.
  always_comb begin
    half_x   = ACC_W'(step_x_r >> 1);
    half_y   = ACC_W'(step_y_r >> 1);
    col_cur  = in_restart ? '0 : col_r;
    row_cur  = in_restart ? '0 : row_r;
    xacc_cur = in_restart ? half_x : xacc_r;
    yacc_cur = in_restart ? half_y : yacc_r;
  end

  // Source address, clamp and mirror, end marks.
  always_comb begin
    xi        = xacc_cur[ACC_W-1:FRAC_W];
    yi        = yacc_cur[ACC_W-1:FRAC_W];
    sw_m1_ext = INT_W'(sw_m1_r);
    sh_m1_ext = INT_W'(sh_m1_r);
    scol_full = (xi >= sw_m1_ext) ? sw_m1_ext : xi;
    srow_full = (yi >= sh_m1_ext) ? '0 : (sh_m1_ext - yi);
    eor       = (col_cur >= tw_m1_r);
    eof       = eor && (row_cur >= th_m1_r);

    res.dest_col     = COORD_W'(col_cur);
    res.dest_row     = COORD_W'(row_cur);
    res.src_col      = scol_full[COORD_W-1:0];
    res.src_row      = srow_full[COORD_W-1:0];
    res.end_of_row   = eor;
    res.end_of_frame = eof;
  end

  // Advance to the next pixel; wrap the row and the frame.
  always_comb begin
    if (eof) begin
      col_nxt  = '0;
      row_nxt  = '0;
      xacc_nxt = half_x;
      yacc_nxt = half_y;
    end else if (eor) begin
      col_nxt  = '0;
      row_nxt  = row_cur + CNT_W'(1);
      xacc_nxt = half_x;
      yacc_nxt = yacc_cur + ACC_W'(step_y_r);
    end else begin
      col_nxt  = col_cur + CNT_W'(1);
      row_nxt  = row_cur;
      xacc_nxt = xacc_cur + ACC_W'(step_x_r);
      yacc_nxt = yacc_cur;
    end
  end

  // Position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      xacc_r <= ACC_W'(STEP_ONE >> 1);
      yacc_r <= ACC_W'(STEP_ONE >> 1);
    end else if (in_acc) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      xacc_r <= xacc_nxt;
      yacc_r <= yacc_nxt;
    end
  end

  // Output register and skid register control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r | in_acc;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_acc) begin
        out_r <= res;
      end
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_col     = out_r.dest_col;
  assign out_dest_row     = out_r.dest_row;
  assign out_src_col      = out_r.src_col;
  assign out_src_row      = out_r.src_row;
  assign out_end_of_row   = out_r.end_of_row;
  assign out_end_of_frame = out_r.end_of_frame;

`ifndef NO_ASSERTIONS
  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a transaction with the output register empty");

  // An accepted transaction always shows up in the output stage next cycle.
  a_accept_visible: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted transaction missing from the output stage");

  // The end of a frame is also the end of a row.
  a_eof_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.end_of_frame || out_r.end_of_row))
    else $error("end of frame without end of row");

  // After the last pixel of a frame the position wraps to zero.
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && eof) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap after end of frame");

  // Inside a row the column advances by one.
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !eor) |=> (col_r == $past(col_cur) + CNT_W'(1)))
    else $error("column did not advance by one");
`endif

endmodule
